// ===== hdl/rssg_pkg.sv =====
// ---------------------------------------------------------------------------
// rssg_pkg
// Shared types and constants of the ramp/soak setpoint generator.
// ---------------------------------------------------------------------------
package rssg_pkg;

    localparam int NUM_TABLES_DEF   = 16;
    localparam int POINTS_DEF       = 8;

    localparam int TEMP_W           = 16;
    localparam int TIME_W           = 16;
    localparam int CNT_W            = 4;
    localparam int POINT_W          = TIME_W + TEMP_W;

    localparam int SLOPE_FRAC       = 7;
    localparam logic [TEMP_W-1:0] AMBIENT_RESET = 16'(25 << 2);

    // slope divider: |dtemp| << SLOPE_FRAC over |dtime|
    localparam int DIV_NUM_W        = TEMP_W + SLOPE_FRAC;
    localparam int DIV_DEN_W        = TIME_W;
    localparam int DIV_STEPS        = DIV_NUM_W;

    typedef enum logic [1:0] {
        MODE_QUERY = 2'd0,
        MODE_POINT = 2'd1,
        MODE_COUNT = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_COUNT,
        ST_CHECK,
        ST_POINT,
        ST_SLOPE,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [7:0]        table_sel;
        logic [2:0]        point_index;
        logic [TIME_W-1:0] point_time;
        logic [TEMP_W-1:0] point_temp;
        logic [CNT_W-1:0]  point_count;
        logic [TIME_W-1:0] query_time;
    } req_t;

    typedef struct packed {
        logic [TEMP_W-1:0] setpoint;
        logic              profile_done;
        logic [CNT_W-1:0]  segment_index;
    } rsp_t;

endpackage

// ===== hdl/rssg_if.sv =====
// ---------------------------------------------------------------------------
// rssg_if
// Valid/ready channels of the setpoint generator: items, results, config.
// ---------------------------------------------------------------------------
interface rssg_req_if
    import rssg_pkg::*;
;
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rssg_rsp_if
    import rssg_pkg::*;
;
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rssg_cfg_if
    import rssg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TEMP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/rssg_store.sv =====
// ---------------------------------------------------------------------------
// rssg_store
// Profile point memory and point count memory, one port each, read registered.
// ---------------------------------------------------------------------------
module rssg_store
    import rssg_pkg::*;
#(
    parameter int NUM_TABLES       = NUM_TABLES_DEF,
    parameter int POINTS_PER_TABLE = POINTS_DEF,
    localparam int DEPTH = NUM_TABLES * POINTS_PER_TABLE,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1
)
(
    input  logic               clk,
    input  logic               pt_we,
    input  logic [AW-1:0]      pt_addr,
    input  logic [POINT_W-1:0] pt_wdata,
    output logic [POINT_W-1:0] pt_rdata,
    input  logic               cnt_we,
    input  logic [TW-1:0]      cnt_addr,
    input  logic [CNT_W-1:0]   cnt_wdata,
    output logic [CNT_W-1:0]   cnt_rdata
);

    logic [POINT_W-1:0] pt_mem  [DEPTH];
    logic [CNT_W-1:0]   cnt_mem [NUM_TABLES];

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[pt_addr] <= pt_wdata;
        end
        pt_rdata <= pt_mem[pt_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_addr] <= cnt_wdata;
        end
        cnt_rdata <= cnt_mem[cnt_addr];
    end

endmodule

// ===== hdl/rssg_div.sv =====
// ---------------------------------------------------------------------------
// rssg_div
// Signed truncating slope divider, restoring, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rssg_div
    import rssg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num_mag,
    input  logic [DIV_DEN_W-1:0] den_mag,
    input  logic                 neg,
    output logic                 done,
    output logic [TEMP_W-1:0]    quot
);

    localparam int SW = $clog2(DIV_STEPS);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SW-1:0]        step_reg, step_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic                 neg_reg, neg_next;
    logic [DIV_DEN_W+1:0] diff;
    logic [DIV_NUM_W-1:0] quo_signed;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        diff      = {1'b0, rem_reg, quo_reg[DIV_NUM_W-1]} - {2'b00, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = num_mag;
            den_next  = den_mag;
            neg_next  = neg;
        end
        else if (busy_reg)
        begin
            // keep the trial remainder when the divisor fits
            if (!diff[DIV_DEN_W+1])
            begin
                rem_next = diff[DIV_DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DIV_DEN_W-2:0], quo_reg[DIV_NUM_W-1]};
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == SW'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quot       = quo_signed[TEMP_W-1:0];
    assign done       = done_reg;

endmodule

// ===== hdl/ramp_soak_setpoint_generator_top.sv =====
// ---------------------------------------------------------------------------
// ramp_soak_setpoint_generator_top
// Piecewise linear ramp/soak profile generator with table memories.
// ---------------------------------------------------------------------------
// Channels: req carries one item per beat (query, point or count write),
// rsp returns exactly one result beat per item, cfg (always ready) writes
// the ambient temperature; write it only while idle, the block does not check.
// States from item accept to result valid, with a free result register:
//   point or count write, bad table, time zero: DECODE, EMIT
//   query inside the current segment: DECODE, CHECK, MUL, SUM, EMIT
//   query that crosses into a new segment: DECODE, CHECK, POINT, SLOPE,
//   DIV when the segment has a nonzero time span, then MUL, SUM, EMIT
//   query past the last point: DECODE, CHECK, EMIT (profile_done result)
//   a query that first loads the point count passes COUNT after DECODE
// The slope divider (one quotient bit per cycle, 23 bits) sets the worst
// case; one item is in flight at a time and req is ready only when idle.
// A new item is taken while the previous result still waits on rsp.
// If rsp stalls, the finished result waits in the working register until
// the output register frees up.
// Reset clears the segment state, sets ambient to 100 quarter degrees
// and leaves the tables undefined: write points and counts before use.
// ---------------------------------------------------------------------------
module ramp_soak_setpoint_generator_top
    import rssg_pkg::*;
#(
    parameter int NUM_TABLES       = NUM_TABLES_DEF,
    parameter int POINTS_PER_TABLE = POINTS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    rssg_req_if.sink  req,
    rssg_rsp_if.source rsp,
    rssg_cfg_if.sink  cfg
);

    localparam int DEPTH = NUM_TABLES * POINTS_PER_TABLE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;

    state_t            state_reg, state_next;
    req_t              item_reg, item_next;
    logic [TEMP_W-1:0] ambient_reg;
    logic [CNT_W-1:0]  loaded_reg, loaded_next;
    logic [CNT_W-1:0]  cur_pt_reg, cur_pt_next;
    logic [TIME_W-1:0] st_time_reg, st_time_next;
    logic [TEMP_W-1:0] st_temp_reg, st_temp_next;
    logic [TIME_W-1:0] end_time_reg, end_time_next;
    logic [TEMP_W-1:0] end_temp_reg, end_temp_next;
    logic [TEMP_W-1:0] slope_reg, slope_next;
    logic signed [32:0] prod_reg, prod_next;
    rsp_t              res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_data_reg, out_data_next;

    logic               tbl_ok, idx_ok;
    logic [TW-1:0]      tbl_idx;
    logic [CNT_W-1:0]   sel_idx;
    logic [AW-1:0]      pt_addr;
    logic               pt_we, cnt_we;
    logic [POINT_W-1:0] pt_rdata;
    logic [CNT_W-1:0]   cnt_rdata, cnt_sat;

    logic signed [TEMP_W:0]  dtemp;
    logic signed [TIME_W:0]  dtime;
    logic [TEMP_W:0]         dtemp_abs, dtime_abs;
    logic                    div_start, div_done;
    logic [TEMP_W-1:0]       div_quot;
    logic signed [TIME_W:0]  dt;
    logic signed [32:0]      prod_shift;

    // ---------------- table addressing ----------------
    assign tbl_ok  = {1'b0, item_reg.table_sel} < 9'(NUM_TABLES);
    assign idx_ok  = {4'b0, item_reg.point_index} < 7'(POINTS_PER_TABLE);
    assign tbl_idx = TW'(item_reg.table_sel);
    assign sel_idx = (state_reg == ST_DECODE) ? {1'b0, item_reg.point_index} : cur_pt_reg;
    assign pt_addr = AW'(int'(tbl_idx) * POINTS_PER_TABLE + int'(sel_idx));
    assign cnt_sat = ({3'b0, item_reg.point_count} > 7'(POINTS_PER_TABLE)) ?
                     CNT_W'(POINTS_PER_TABLE) : item_reg.point_count;

    rssg_store #(
        .NUM_TABLES       (NUM_TABLES),
        .POINTS_PER_TABLE (POINTS_PER_TABLE)
    ) u_store (
        .clk       (clk),
        .pt_we     (pt_we),
        .pt_addr   (pt_addr),
        .pt_wdata  ({item_reg.point_time, item_reg.point_temp}),
        .pt_rdata  (pt_rdata),
        .cnt_we    (cnt_we),
        .cnt_addr  (tbl_idx),
        .cnt_wdata (cnt_sat),
        .cnt_rdata (cnt_rdata)
    );

    // ---------------- slope divider ----------------
    assign dtemp     = $signed({1'b0, end_temp_reg}) - $signed({1'b0, st_temp_reg});
    assign dtime     = $signed({1'b0, end_time_reg}) - $signed({1'b0, st_time_reg});
    assign dtemp_abs = dtemp[TEMP_W] ? (~dtemp + 1'b1) : dtemp;
    assign dtime_abs = dtime[TIME_W] ? (~dtime + 1'b1) : dtime;

    rssg_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_mag ({dtemp_abs[TEMP_W-1:0], {SLOPE_FRAC{1'b0}}}),
        .den_mag (dtime_abs[TIME_W-1:0]),
        .neg     (dtemp[TEMP_W] ^ dtime[TIME_W]),
        .done    (div_done),
        .quot    (div_quot)
    );

    // ---------------- interpolation ----------------
    assign dt         = $signed({1'b0, item_reg.query_time}) - $signed({1'b0, st_time_reg});
    assign prod_shift = prod_reg >>> SLOPE_FRAC;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        loaded_next    = loaded_reg;
        cur_pt_next    = cur_pt_reg;
        st_time_next   = st_time_reg;
        st_temp_next   = st_temp_reg;
        end_time_next  = end_time_reg;
        end_temp_next  = end_temp_reg;
        slope_next     = slope_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        pt_we          = 1'b0;
        cnt_we         = 1'b0;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    item_next  = req.data;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                res_next   = '0;
                state_next = ST_EMIT;
                unique case (item_reg.mode)
                    MODE_POINT:
                    begin
                        pt_we = tbl_ok && idx_ok;
                    end
                    MODE_COUNT:
                    begin
                        cnt_we = tbl_ok;
                    end
                    MODE_QUERY:
                    begin
                        if (item_reg.query_time == '0)
                        begin
                            // time zero rearms the run
                            cur_pt_next   = '0;
                            loaded_next   = '0;
                            slope_next    = '0;
                            end_time_next = '0;
                            end_temp_next = ambient_reg;
                        end
                        else if (!tbl_ok)
                        begin
                            res_next.segment_index = cur_pt_reg;
                        end
                        else if (loaded_reg == '0)
                        begin
                            state_next = ST_COUNT;
                        end
                        else
                        begin
                            state_next = ST_CHECK;
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            ST_COUNT:
            begin
                loaded_next   = cnt_rdata;
                cur_pt_next   = '0;
                end_time_next = '0;
                end_temp_next = ambient_reg;
                slope_next    = '0;
                state_next    = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (item_reg.query_time >= end_time_reg)
                begin
                    if (cur_pt_reg >= loaded_reg)
                    begin
                        // past the last point: report done and rearm
                        res_next      = '{setpoint: '0, profile_done: 1'b1,
                                          segment_index: cur_pt_reg};
                        cur_pt_next   = '0;
                        loaded_next   = '0;
                        end_time_next = '0;
                        end_temp_next = ambient_reg;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_POINT;
                    end
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_POINT:
            begin
                st_time_next  = end_time_reg;
                st_temp_next  = end_temp_reg;
                end_time_next = pt_rdata[POINT_W-1:TEMP_W];
                end_temp_next = pt_rdata[TEMP_W-1:0];
                cur_pt_next   = cur_pt_reg + 1'b1;
                state_next    = ST_SLOPE;
            end
            ST_SLOPE:
            begin
                if (end_time_reg == st_time_reg)
                begin
                    slope_next = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    slope_next = div_quot;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = dt * $signed(slope_reg);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                res_next   = '{setpoint: prod_shift[TEMP_W-1:0] + st_temp_reg,
                               profile_done: 1'b0, segment_index: cur_pt_reg};
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ambient_reg   <= AMBIENT_RESET;
            loaded_reg    <= '0;
            cur_pt_reg    <= '0;
            st_time_reg   <= '0;
            st_temp_reg   <= '0;
            end_time_reg  <= '0;
            end_temp_reg  <= AMBIENT_RESET;
            slope_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg.valid)
            begin
                ambient_reg <= cfg.data;
            end
            loaded_reg    <= loaded_next;
            cur_pt_reg    <= cur_pt_next;
            st_time_reg   <= st_time_next;
            st_temp_reg   <= st_temp_next;
            end_time_reg  <= end_time_next;
            end_temp_reg  <= end_temp_next;
            slope_reg     <= slope_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // ---------------- assertions ----------------
    a_done_zero_setpoint: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.profile_done |-> rsp.data.setpoint == '0)
        else $error("done result carries a nonzero setpoint");

    a_point_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> cur_pt_reg <= loaded_reg)
        else $error("current point ran past the loaded count");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");

    a_emit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && state_next == ST_IDLE |=> rsp.valid)
        else $error("result dropped on the way to the output register");

endmodule
